>>> rtl/palindrome_permutation_substring_counter_macros.svh
// Assertion macros shared by the counter's RTL modules.
// Define NO_ASSERTIONS to compile the checks out.
`ifndef PALINDROME_PERMUTATION_SUBSTRING_COUNTER_MACROS_SVH
`define PALINDROME_PERMUTATION_SUBSTRING_COUNTER_MACROS_SVH

`ifndef NO_ASSERTIONS
`define PPSC_ASSERT(lbl, ck, rn, prop) \
	lbl: assert property (@(posedge ck) disable iff (!rn) prop) \
		else $error("%m: check failed");
`define PPSC_ASSERT_NEVER(lbl, ck, rn, cond) \
	lbl: assert property (@(posedge ck) disable iff (!rn) !(cond)) \
		else $error("%m: forbidden condition");
`else
`define PPSC_ASSERT(lbl, ck, rn, prop)
`define PPSC_ASSERT_NEVER(lbl, ck, rn, cond)
`endif

`endif

>>> rtl/ppsc_pkg.sv
// Package of the palindrome permutation substring counter: constants, word
// types, controller states and the command and status bundles.
// No dependencies.
`default_nettype none

package ppsc_pkg;

	localparam int ALPHABET_BITS   = 10;
	localparam int SEEN_COUNT_BITS = 32;

	localparam int LETTER_W    = 10;
	localparam int TOTAL_W     = 48;
	localparam int ADDR_W      = ALPHABET_BITS;
	localparam int TABLE_DEPTH = 1 << ALPHABET_BITS;
	localparam int EPOCH_W     = 8;
	localparam int ENTRY_W     = SEEN_COUNT_BITS + EPOCH_W;
	localparam int BIT_W       = $clog2(ALPHABET_BITS + 1);

	typedef struct packed {
		logic [LETTER_W-1:0] letter;
		logic                start_string;
	} ppsc_in_t;

	typedef struct packed {
		logic [TOTAL_W-1:0] substring_total;
		logic               prefix_can_form;
	} ppsc_out_t;

	typedef enum logic [3:0] {
		ST_INIT,
		ST_IDLE,
		ST_START,
		ST_WIPE,
		ST_BEGIN,
		ST_FLIP,
		ST_READ,
		ST_DRAIN,
		ST_WRITE,
		ST_EMIT
	} ppsc_state_t;

	typedef struct packed {
		logic idle;
		logic load;
		logic wipe;
		logic begin_str;
		logic flip;
		logic read;
		logic write;
		logic emit;
	} ppsc_cmd_t;

	typedef struct packed {
		logic start_req;
		logic epoch_full;
		logic letter_ok;
		logic read_last;
		logic wipe_last;
		logic out_free;
	} ppsc_sts_t;

endpackage

`default_nettype wire

>>> rtl/palindrome_permutation_substring_counter.sv
// Palindrome permutation substring counter. A letter word that starts a string first
// goes through the begin step; a letter outside the alphabet skips the table reads.
// The single-port seen-count table is read once per mask and neighbor, and the input
// is stalled until each letter's result is emitted. After reset the whole table is wiped
// with the input stalled; every 255th string start wipes it again before its letter is
// handled. Depends on ppsc_pkg, ppsc_ctrl and ppsc_dpath.
`default_nettype none

module palindrome_permutation_substring_counter (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                src_valid,
	output logic                src_stall,
	input  ppsc_pkg::ppsc_in_t  src_data,
	output logic                dst_valid,
	input  logic                dst_stall,
	output ppsc_pkg::ppsc_out_t dst_data
);
	import ppsc_pkg::*;

	ppsc_cmd_t cmd;
	ppsc_sts_t sts;

	ppsc_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.src_valid (src_valid),
		.sts       (sts),
		.cmd       (cmd)
	);

	ppsc_dpath u_dpath (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.sts       (sts),
		.src_data  (src_data),
		.dst_valid (dst_valid),
		.dst_stall (dst_stall),
		.dst_data  (dst_data)
	);

	assign src_stall = !cmd.idle;

endmodule

`default_nettype wire

>>> rtl/ppsc_dpath.sv
// Datapath of the counter: item and mask registers, epoch-tagged seen-count
// memory, saturating accumulator and output register.
// Depends on ppsc_pkg and the assertion macro header.
`default_nettype none
`include "palindrome_permutation_substring_counter_macros.svh"

module ppsc_dpath (
	input  logic                clk,
	input  logic                arst_n,
	input  ppsc_pkg::ppsc_cmd_t cmd,
	output ppsc_pkg::ppsc_sts_t sts,
	input  ppsc_pkg::ppsc_in_t  src_data,
	output logic                dst_valid,
	input  logic                dst_stall,
	output ppsc_pkg::ppsc_out_t dst_data
);
	import ppsc_pkg::*;

	localparam logic [SEEN_COUNT_BITS-1:0] COUNT_MAX = '1;
	localparam logic [TOTAL_W-1:0]         TOTAL_MAX = '1;

	logic [ENTRY_W-1:0] seen_mem [TABLE_DEPTH];

	logic [LETTER_W-1:0]        letter_q;
	logic                       start_q;
	logic [ADDR_W-1:0]          mask_q;
	logic [TOTAL_W-1:0]         total_q;
	logic [EPOCH_W-1:0]         epoch_q;
	logic [BIT_W-1:0]           bit_q;
	logic [ADDR_W-1:0]          clr_q;
	logic [SEEN_COUNT_BITS-1:0] self_q;
	logic [ENTRY_W-1:0]         rd_data_s1;
	logic [ADDR_W-1:0]          rd_addr_s1;
	logic                       rd_vld_s1;
	logic                       rd_self_s1;
	logic                       dst_valid_q;
	ppsc_out_t                  dst_data_q;

	logic [ADDR_W-1:0]          letter_hot;
	logic [BIT_W-1:0]           bit_idx;
	logic [ADDR_W-1:0]          nb_hot;
	logic [ADDR_W-1:0]          rd_addr;
	logic [ADDR_W-1:0]          mem_addr;
	logic [ENTRY_W-1:0]         wr_data;
	logic [SEEN_COUNT_BITS-1:0] cnt_inc;
	logic [EPOCH_W-1:0]         rd_tag;
	logic [SEEN_COUNT_BITS-1:0] rd_val;
	logic [TOTAL_W:0]           sum;
	logic [TOTAL_W-1:0]         sum_sat;
	logic                       can_form;

	assign letter_hot = ADDR_W'(1) << letter_q;
	assign bit_idx    = bit_q - BIT_W'(1);
	assign nb_hot     = ADDR_W'(1) << bit_idx;
	assign rd_addr    = (bit_q == '0) ? mask_q : (mask_q ^ nb_hot);
	assign mem_addr   = cmd.wipe ? clr_q : (cmd.write ? mask_q : rd_addr);
	assign cnt_inc    = (self_q == COUNT_MAX) ? self_q : self_q + SEEN_COUNT_BITS'(1);
	assign wr_data    = cmd.wipe ? '0 : {epoch_q, cnt_inc};

	assign rd_tag  = rd_data_s1[ENTRY_W-1 -: EPOCH_W];
	assign rd_val  = (rd_tag == epoch_q) ? rd_data_s1[SEEN_COUNT_BITS-1:0] :
			((rd_addr_s1 == '0) ? SEEN_COUNT_BITS'(1) : '0);
	assign sum     = {1'b0, total_q} + (TOTAL_W + 1)'(rd_val);
	assign sum_sat = sum[TOTAL_W] ? TOTAL_MAX : sum[TOTAL_W-1:0];

	assign can_form = ((mask_q & (mask_q - ADDR_W'(1))) == '0);

	always_ff @(posedge clk) begin
		if (cmd.wipe || cmd.write) begin
			seen_mem[mem_addr] <= wr_data;
		end else if (cmd.read) begin
			rd_data_s1 <= seen_mem[mem_addr];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			letter_q <= src_data.letter;
			start_q  <= src_data.start_string;
		end
		rd_addr_s1 <= rd_addr;
		rd_self_s1 <= cmd.read && (bit_q == '0);
		if (rd_vld_s1 && rd_self_s1) begin
			self_q <= rd_val;
		end
		if (cmd.emit) begin
			dst_data_q.substring_total <= total_q;
			dst_data_q.prefix_can_form <= can_form;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mask_q      <= '0;
			total_q     <= '0;
			epoch_q     <= EPOCH_W'(1);
			bit_q       <= '0;
			clr_q       <= '0;
			rd_vld_s1   <= 1'b0;
			dst_valid_q <= 1'b0;
		end else begin
			rd_vld_s1 <= cmd.read;
			bit_q     <= cmd.read ? bit_q + BIT_W'(1) : '0;
			if (cmd.wipe) begin
				clr_q <= clr_q + ADDR_W'(1);
			end
			if (cmd.begin_str) begin
				mask_q  <= '0;
				total_q <= '0;
				epoch_q <= (&epoch_q) ? EPOCH_W'(1) : epoch_q + EPOCH_W'(1);
			end else begin
				if (cmd.flip) begin
					mask_q <= mask_q ^ letter_hot;
				end
				if (rd_vld_s1) begin
					total_q <= sum_sat;
				end
			end
			if (cmd.emit) begin
				dst_valid_q <= 1'b1;
			end else if (!dst_stall) begin
				dst_valid_q <= 1'b0;
			end
		end
	end

	assign sts.start_req  = start_q;
	assign sts.epoch_full = &epoch_q;
	assign sts.letter_ok  = (letter_q < LETTER_W'(ALPHABET_BITS));
	assign sts.read_last  = (bit_q == BIT_W'(ALPHABET_BITS));
	assign sts.wipe_last  = &clr_q;
	assign sts.out_free   = !dst_valid_q || !dst_stall;

	assign dst_valid = dst_valid_q;
	assign dst_data  = dst_data_q;

	`PPSC_ASSERT_NEVER(a_port_excl, clk, arst_n, cmd.write && (rd_vld_s1 || cmd.read))
	`PPSC_ASSERT(a_total_mono, clk, arst_n, !cmd.begin_str |=> total_q >= $past(total_q))
	`PPSC_ASSERT(a_self_addr, clk, arst_n, rd_vld_s1 && rd_self_s1 |-> rd_addr_s1 == mask_q)

endmodule

`default_nettype wire

>>> rtl/ppsc_ctrl.sv
// Controller of the counter: sequences table wipe, string start, mask flip,
// neighbor reads, table update and result hand-off.
// Depends on ppsc_pkg and the assertion macro header.
`default_nettype none
`include "palindrome_permutation_substring_counter_macros.svh"

module ppsc_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                src_valid,
	input  ppsc_pkg::ppsc_sts_t sts,
	output ppsc_pkg::ppsc_cmd_t cmd
);
	import ppsc_pkg::*;

	ppsc_state_t state_q;
	ppsc_state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_INIT;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_INIT: begin
				if (sts.wipe_last) state_d = ST_IDLE;
			end
			ST_IDLE: begin
				if (src_valid) state_d = ST_START;
			end
			ST_START: begin
				priority if (sts.start_req && sts.epoch_full) state_d = ST_WIPE;
				else if (sts.start_req) state_d = ST_BEGIN;
				else if (sts.letter_ok) state_d = ST_FLIP;
				else state_d = ST_EMIT;
			end
			ST_WIPE: begin
				if (sts.wipe_last) state_d = ST_BEGIN;
			end
			ST_BEGIN: begin
				state_d = sts.letter_ok ? ST_FLIP : ST_EMIT;
			end
			ST_FLIP: state_d = ST_READ;
			ST_READ: begin
				if (sts.read_last) state_d = ST_DRAIN;
			end
			ST_DRAIN: state_d = ST_WRITE;
			ST_WRITE: state_d = ST_EMIT;
			ST_EMIT: begin
				if (sts.out_free) state_d = ST_IDLE;
			end
			default: state_d = ST_INIT;
		endcase
	end

	always_comb begin
		cmd           = '0;
		cmd.idle      = (state_q == ST_IDLE);
		cmd.load      = (state_q == ST_IDLE) && src_valid;
		cmd.wipe      = (state_q == ST_INIT) || (state_q == ST_WIPE);
		cmd.begin_str = (state_q == ST_BEGIN);
		cmd.flip      = (state_q == ST_FLIP);
		cmd.read      = (state_q == ST_READ);
		cmd.write     = (state_q == ST_WRITE);
		cmd.emit      = (state_q == ST_EMIT) && sts.out_free;
	end

	`PPSC_ASSERT(a_drain_after_read, clk, arst_n, state_q == ST_DRAIN |-> $past(state_q == ST_READ))
	`PPSC_ASSERT(a_read_end, clk, arst_n, state_q == ST_READ && sts.read_last |=> state_q == ST_DRAIN)
	`PPSC_ASSERT(a_wipe_cause, clk, arst_n, state_q == ST_WIPE |-> sts.start_req && sts.epoch_full)

endmodule

`default_nettype wire
